// ----- hdl/tun_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants and types for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

   localparam int COORD_WIDTH_DEF      = 16;
   localparam int NORMAL_FRAC_BITS_DEF = 14;

   // scaled cross product magnitudes are kept below 2^Q_WIDTH
   localparam int Q_WIDTH    = 31;
   localparam int SQ_WIDTH   = 2 * Q_WIDTH;
   localparam int SUM_WIDTH  = SQ_WIDTH + 2;
   localparam int ROOT_WIDTH = SUM_WIDTH / 2;

   typedef struct packed {
      logic [2:0][Q_WIDTH-1:0] q;
      logic [2:0]              neg;
      logic                    degen;
   } side_type;

endpackage
`default_nettype wire

// ----- hdl/tun_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tun_req_if / tun_rsp_if
// Valid/ready channels carrying one face request and one normal result.
// ----------------------------------------------------------------------------
interface tun_req_if import tun_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_x;
   logic signed [COORD_WIDTH-1:0] a_y;
   logic signed [COORD_WIDTH-1:0] a_z;
   logic signed [COORD_WIDTH-1:0] b_x;
   logic signed [COORD_WIDTH-1:0] b_y;
   logic signed [COORD_WIDTH-1:0] b_z;
   logic signed [COORD_WIDTH-1:0] c_x;
   logic signed [COORD_WIDTH-1:0] c_y;
   logic signed [COORD_WIDTH-1:0] c_z;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   input ready);
   modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                 output ready);
endinterface

interface tun_rsp_if import tun_pkg::*; #(
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) ();
   logic                                 valid;
   logic                                 ready;
   logic signed [NORMAL_FRAC_BITS+1:0]   norm_x;
   logic signed [NORMAL_FRAC_BITS+1:0]   norm_y;
   logic signed [NORMAL_FRAC_BITS+1:0]   norm_z;
   logic                                 degenerate;

   modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
   modport sink (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface
`default_nettype wire

// ----- hdl/triangle_unit_normal.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle: edge vectors, cross product, scaling,
// pipelined square root (one root bit per stage) and pipelined division
// (one quotient bit per stage, three lanes).
// Throughput: one request per cycle; each stage holds only while its
// successor is full and stalled, so bubbles close up under backpressure.
// Reset: synchronous, clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module triangle_unit_normal import tun_pkg::*; #(
   parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tun_req_if.sink    req_chan,
   tun_rsp_if.source  rsp_chan
);

   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int MAG_W   = (CROSS_W > Q_WIDTH) ? CROSS_W : Q_WIDTH;
   localparam int SHIFT_W = $clog2(MAG_W);
   localparam int OUT_W   = NORMAL_FRAC_BITS + 2;
   localparam int QUO_W   = NORMAL_FRAC_BITS + 1;
   localparam int DIV_W   = ROOT_WIDTH + QUO_W;

   localparam int ST_DIFF  = 0;
   localparam int ST_PROD  = 1;
   localparam int ST_CROSS = 2;
   localparam int ST_NORM  = 3;
   localparam int ST_SQ    = 4;
   localparam int ST_SUM   = 5;
   localparam int ST_SQRT  = 6;
   localparam int ST_NUM   = ST_SQRT + ROOT_WIDTH;
   localparam int ST_OUT   = ST_NUM + QUO_W + 1;
   localparam int NSTG     = ST_OUT + 1;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] adv;

   logic signed [DIFF_W-1:0]  d_ff [6];
   logic signed [PROD_W-1:0]  p_ff [6];
   logic signed [CROSS_W-1:0] r_ff [3];
   side_type                  side_ff [ST_NORM:ST_OUT-1];
   logic [SQ_WIDTH-1:0]       sq_ff [3];
   logic [SUM_WIDTH-1:0]      sum_ff;
   logic [SUM_WIDTH-1:0]      rt_rem_ff [ROOT_WIDTH-1];
   logic [ROOT_WIDTH-1:0]     rt_root_ff [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0]     dv_len_ff [QUO_W];
   logic [2:0][DIV_W-1:0]     dv_rem_ff [QUO_W];
   logic [2:0][QUO_W-1:0]     dv_quo_ff [1:QUO_W];
   logic signed [OUT_W-1:0]   nx_ff, ny_ff, nz_ff;
   logic                      deg_ff;

   // stall chain
   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || rsp_chan.ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_chan.ready = adv[ST_DIFF];

   // edge vectors: ux uy uz vx vy vz
   always_ff @(posedge clock) begin
      if (adv[ST_DIFF]) begin
         d_ff[0] <= DIFF_W'(req_chan.b_x) - DIFF_W'(req_chan.a_x);
         d_ff[1] <= DIFF_W'(req_chan.b_y) - DIFF_W'(req_chan.a_y);
         d_ff[2] <= DIFF_W'(req_chan.b_z) - DIFF_W'(req_chan.a_z);
         d_ff[3] <= DIFF_W'(req_chan.c_x) - DIFF_W'(req_chan.a_x);
         d_ff[4] <= DIFF_W'(req_chan.c_y) - DIFF_W'(req_chan.a_y);
         d_ff[5] <= DIFF_W'(req_chan.c_z) - DIFF_W'(req_chan.a_z);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_PROD]) begin
         p_ff[0] <= d_ff[1] * d_ff[5];
         p_ff[1] <= d_ff[2] * d_ff[4];
         p_ff[2] <= d_ff[2] * d_ff[3];
         p_ff[3] <= d_ff[0] * d_ff[5];
         p_ff[4] <= d_ff[0] * d_ff[4];
         p_ff[5] <= d_ff[1] * d_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_CROSS]) begin
         r_ff[0] <= CROSS_W'(p_ff[0]) - CROSS_W'(p_ff[1]);
         r_ff[1] <= CROSS_W'(p_ff[2]) - CROSS_W'(p_ff[3]);
         r_ff[2] <= CROSS_W'(p_ff[4]) - CROSS_W'(p_ff[5]);
      end
   end

   // magnitudes, common right shift into Q_WIDTH bits
   logic [MAG_W-1:0]   mag [3];
   logic [MAG_W-1:0]   mag_or;
   logic [SHIFT_W-1:0] shamt;
   side_type           norm_in;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag[l] = r_ff[l][CROSS_W-1] ? MAG_W'(-r_ff[l]) : MAG_W'(r_ff[l]);
      end
      mag_or = mag[0] | mag[1] | mag[2];
      shamt  = '0;
      for (int k = Q_WIDTH; k < MAG_W; k++) begin
         if (mag_or[k]) begin
            shamt = SHIFT_W'(k - Q_WIDTH + 1);
         end
      end
      for (int l = 0; l < 3; l++) begin
         norm_in.q[l]   = Q_WIDTH'(mag[l] >> shamt);
         norm_in.neg[l] = r_ff[l][CROSS_W-1];
      end
      norm_in.degen = (mag_or == '0);
   end

   always_ff @(posedge clock) begin
      if (adv[ST_NORM]) begin
         side_ff[ST_NORM] <= norm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_SQ]) begin
         side_ff[ST_SQ] <= side_ff[ST_NORM];
         for (int l = 0; l < 3; l++) begin
            sq_ff[l] <= SQ_WIDTH'(side_ff[ST_NORM].q[l]) * SQ_WIDTH'(side_ff[ST_NORM].q[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_SUM]) begin
         side_ff[ST_SUM] <= side_ff[ST_SQ];
         sum_ff <= SUM_WIDTH'(sq_ff[0]) + SUM_WIDTH'(sq_ff[1]) + SUM_WIDTH'(sq_ff[2]);
      end
   end

   // square root, one result bit per stage, most significant first
   for (genvar j = 0; j < ROOT_WIDTH; j++) begin : g_sqrt
      localparam int BIT = ROOT_WIDTH - 1 - j;
      localparam int IDX = ST_SQRT + j;
      logic [SUM_WIDTH-1:0]  rem_prev;
      logic [SUM_WIDTH-1:0]  trial;
      logic [ROOT_WIDTH-1:0] root_prev;
      logic                  take;

      if (j == 0) begin : g_first
         assign rem_prev  = sum_ff;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rt_rem_ff[j-1];
         assign root_prev = rt_root_ff[j-1];
      end

      assign trial = (SUM_WIDTH'(root_prev) << (BIT + 1)) | (SUM_WIDTH'(1) << (2 * BIT));
      assign take  = (rem_prev >= trial);

      always_ff @(posedge clock) begin
         if (adv[IDX]) begin
            side_ff[IDX]  <= side_ff[IDX-1];
            rt_root_ff[j] <= take ? (root_prev | (ROOT_WIDTH'(1) << BIT)) : root_prev;
         end
      end

      if (j < ROOT_WIDTH - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv[IDX]) begin
               rt_rem_ff[j] <= take ? (rem_prev - trial) : rem_prev;
            end
         end
      end
   end

   // rounded dividend: q * 2^F + floor(L / 2)
   always_ff @(posedge clock) begin
      if (adv[ST_NUM]) begin
         side_ff[ST_NUM] <= side_ff[ST_NUM-1];
         dv_len_ff[0]    <= rt_root_ff[ROOT_WIDTH-1];
         for (int l = 0; l < 3; l++) begin
            dv_rem_ff[0][l] <= (DIV_W'(side_ff[ST_NUM-1].q[l]) << NORMAL_FRAC_BITS)
                             + DIV_W'(rt_root_ff[ROOT_WIDTH-1] >> 1);
         end
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar d = 1; d <= QUO_W; d++) begin : g_div
      localparam int BIT = QUO_W - d;
      localparam int IDX = ST_NUM + d;
      logic [DIV_W-1:0]       trial;
      logic [2:0][QUO_W-1:0]  quo_prev;
      logic [2:0]             take;

      if (d == 1) begin : g_first
         assign quo_prev = '0;
      end else begin : g_next
         assign quo_prev = dv_quo_ff[d-1];
      end

      assign trial = DIV_W'(dv_len_ff[d-1]) << BIT;

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            take[l] = (dv_rem_ff[d-1][l] >= trial);
         end
      end

      always_ff @(posedge clock) begin
         if (adv[IDX]) begin
            side_ff[IDX] <= side_ff[IDX-1];
            for (int l = 0; l < 3; l++) begin
               dv_quo_ff[d][l] <= take[l] ? (quo_prev[l] | (QUO_W'(1) << BIT))
                                          : quo_prev[l];
            end
         end
      end

      if (d < QUO_W) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv[IDX]) begin
               dv_len_ff[d] <= dv_len_ff[d-1];
               for (int l = 0; l < 3; l++) begin
                  dv_rem_ff[d][l] <= take[l] ? (dv_rem_ff[d-1][l] - trial)
                                             : dv_rem_ff[d-1][l];
               end
            end
         end
      end
   end

   // sign and degenerate override
   logic signed [OUT_W-1:0] sgn_in [3];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (side_ff[ST_OUT-1].degen) begin
            sgn_in[l] = '0;
         end else if (side_ff[ST_OUT-1].neg[l]) begin
            sgn_in[l] = -OUT_W'(dv_quo_ff[QUO_W][l]);
         end else begin
            sgn_in[l] = OUT_W'(dv_quo_ff[QUO_W][l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         nx_ff  <= sgn_in[0];
         ny_ff  <= sgn_in[1];
         nz_ff  <= sgn_in[2];
         deg_ff <= side_ff[ST_OUT-1].degen;
      end
   end

   assign rsp_chan.valid      = vld_ff[ST_OUT];
   assign rsp_chan.norm_x     = nx_ff;
   assign rsp_chan.norm_y     = ny_ff;
   assign rsp_chan.norm_z     = nz_ff;
   assign rsp_chan.degenerate = deg_ff;

endmodule
`default_nettype wire

// ----- hdl/tun_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tun_checker
// Port-level checks on the normal result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tun_checker import tun_pkg::*; #(
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [NORMAL_FRAC_BITS+1:0] rsp_norm_x,
   input wire logic signed [NORMAL_FRAC_BITS+1:0] rsp_norm_y,
   input wire logic signed [NORMAL_FRAC_BITS+1:0] rsp_norm_z,
   input wire logic                               rsp_degenerate
);

   localparam int OUT_W = NORMAL_FRAC_BITS + 2;
   localparam logic signed [OUT_W-1:0] NORM_ONE   = OUT_W'(1) << NORMAL_FRAC_BITS;
   localparam logic signed [OUT_W-1:0] NORM_M_ONE = -NORM_ONE;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_norm_x)
         && $stable(rsp_norm_y) && $stable(rsp_norm_z) && $stable(rsp_degenerate))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_norm_x == '0 && rsp_norm_y == '0
         && rsp_norm_z == '0)
      else $error("degenerate face with nonzero normal");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_norm_x <= NORM_ONE && rsp_norm_x >= NORM_M_ONE
         && rsp_norm_y <= NORM_ONE && rsp_norm_y >= NORM_M_ONE
         && rsp_norm_z <= NORM_ONE && rsp_norm_z >= NORM_M_ONE)
      else $error("normal component beyond unit range");

endmodule

bind triangle_unit_normal tun_checker #(
   .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
) u_tun_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_norm_x     (rsp_chan.norm_x),
   .rsp_norm_y     (rsp_chan.norm_y),
   .rsp_norm_z     (rsp_chan.norm_z),
   .rsp_degenerate (rsp_chan.degenerate)
);
`default_nettype wire
